// ----- sv/jetp_pkg.sv -----
// ----------------------------------------------------------------------------
// jetp_pkg: shared types and constants of the Julia escape-time pixel core
// Register map, fixed data widths, back-end state type and saturation helper.
// ----------------------------------------------------------------------------
package jetp_pkg;

    localparam int DATA_W     = 32;   // Q-format word width
    localparam int LIMIT_W    = 16;   // iteration_limit register width
    localparam int CFG_IDX_W  = 4;    // config index, room for unused codes
    localparam int CFG_DATA_W = 64;   // widest register (shift pair)
    localparam int SAT_IN_W   = 68;   // working width ahead of saturation

    localparam int COORD_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 28;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_ORIGIN_RE = 4'd0;
    localparam t_cfg_idx REG_ORIGIN_IM = 4'd1;
    localparam t_cfg_idx REG_STEP_RE   = 4'd2;
    localparam t_cfg_idx REG_STEP_IM   = 4'd3;
    localparam t_cfg_idx REG_CONST_RE  = 4'd4;
    localparam t_cfg_idx REG_CONST_IM  = 4'd5;
    localparam t_cfg_idx REG_SHIFT     = 4'd6;
    localparam t_cfg_idx REG_LIMIT     = 4'd7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd255;

    // floor(m / 10) = (m * RECIP10) >> RECIP10_SH for any 32-bit unsigned m
    localparam logic [DATA_W-1:0] RECIP10    = 32'hCCCC_CCCD;
    localparam int                RECIP10_SH = 35;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHECK,
        BK_SQ_ZR,
        BK_SQ_ZI,
        BK_TEST,
        BK_SQ_WI,
        BK_MUL_X,
        BK_UPDATE
    } t_bk_state;

    localparam logic signed [SAT_IN_W-1:0] SAT_MAX = 68'sd2147483647;
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN = -68'sd2147483648;

    function automatic logic signed [DATA_W-1:0] sat32(
        input logic signed [SAT_IN_W-1:0] v
    );
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/jetp_fifo.sv -----
// ----------------------------------------------------------------------------
// jetp_fifo: short word queue between front and back end
// Flip-flop storage, combinational read of the head word.
// ----------------------------------------------------------------------------
module jetp_fifo #(
    parameter int WIDTH = 88
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    import jetp_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + AW'(1);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= inc_ptr(r_wr);
            end
            if (i_pop) begin
                r_rd <= inc_ptr(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));

endmodule

// ----- sv/jetp_front.sv -----
// ----------------------------------------------------------------------------
// jetp_front: pixel intake and start-point mapping
// z0 = sat(origin + ((2*index+1)*step >>> 1)) per axis, two register stages.
// ----------------------------------------------------------------------------
module jetp_front #(
    parameter int COORD_BITS = jetp_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_take,
    input  logic [COORD_BITS-1:0]              i_pixel_x,
    input  logic [COORD_BITS-1:0]              i_pixel_y,
    input  logic signed [jetp_pkg::DATA_W-1:0] i_origin_re,
    input  logic signed [jetp_pkg::DATA_W-1:0] i_origin_im,
    input  logic signed [jetp_pkg::DATA_W-1:0] i_step_re,
    input  logic signed [jetp_pkg::DATA_W-1:0] i_step_im,
    output logic                               o_active,
    output logic                               o_push,
    output logic [2*COORD_BITS+2*jetp_pkg::DATA_W-1:0] o_item
);
    import jetp_pkg::*;

    localparam int PW = COORD_BITS + 2 + DATA_W;

    logic                  r_v0;
    logic                  r_v1;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic signed [PW-1:0]  r_prod_x;
    logic signed [PW-1:0]  r_prod_y;

    logic signed [PW-1:0]     w_prod_x;
    logic signed [PW-1:0]     w_prod_y;
    logic signed [DATA_W-1:0] w_z0_re;
    logic signed [DATA_W-1:0] w_z0_im;

    // {index, 1} is 2*index+1, always positive
    assign w_prod_x = $signed({1'b0, r_px, 1'b1}) * i_step_re;
    assign w_prod_y = $signed({1'b0, r_py, 1'b1}) * i_step_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_take;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (r_v0) begin
            r_prod_x <= w_prod_x;
            r_prod_y <= w_prod_y;
        end
    end

    assign w_z0_re = sat32(SAT_IN_W'(r_prod_x >>> 1) + SAT_IN_W'(i_origin_re));
    assign w_z0_im = sat32(SAT_IN_W'(r_prod_y >>> 1) + SAT_IN_W'(i_origin_im));

    assign o_active = r_v0 | r_v1;
    assign o_push   = r_v1;
    assign o_item   = {r_px, r_py, w_z0_re, w_z0_im};

endmodule

// ----- sv/jetp_iter.sv -----
// ----------------------------------------------------------------------------
// jetp_iter: escape-time iteration engine
// One shared 32x32 multiplier stepped by a small sequencer.
// ----------------------------------------------------------------------------
module jetp_iter #(
    parameter int COORD_BITS = jetp_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = jetp_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = jetp_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_empty,
    input  logic [2*COORD_BITS+2*jetp_pkg::DATA_W-1:0] i_item,
    output logic                               o_pop,
    input  logic signed [jetp_pkg::DATA_W-1:0] i_const_re,
    input  logic signed [jetp_pkg::DATA_W-1:0] i_const_im,
    input  logic [jetp_pkg::CFG_DATA_W-1:0]    i_shift_pair,
    input  logic [jetp_pkg::LIMIT_W-1:0]       i_limit,
    output logic                               o_strobe,
    output logic [COORD_BITS-1:0]              o_out_x,
    output logic [COORD_BITS-1:0]              o_out_y,
    output logic [COUNT_BITS-1:0]              o_iterations,
    output logic                               o_escaped
);
    import jetp_pkg::*;

    localparam int NW = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam logic [63:0] BOUND = 64'd4 << (2 * FRAC_BITS);

    // ---- shift / 10, recomputed from the register in two stages ----
    logic [DATA_W-1:0]        w_mag_re;
    logic [DATA_W-1:0]        w_mag_im;
    logic [63:0]              r_dprod_re;
    logic [63:0]              r_dprod_im;
    logic                     r_dneg_re;
    logic                     r_dneg_im;
    logic signed [DATA_W-1:0] r_sr;
    logic signed [DATA_W-1:0] r_si;
    logic [DATA_W-1:0]        w_q_re;
    logic [DATA_W-1:0]        w_q_im;

    assign w_mag_re = i_shift_pair[31] ? (~i_shift_pair[31:0] + 32'd1) : i_shift_pair[31:0];
    assign w_mag_im = i_shift_pair[63] ? (~i_shift_pair[63:32] + 32'd1)
                                       : i_shift_pair[63:32];
    assign w_q_re = DATA_W'(r_dprod_re[63:RECIP10_SH]);
    assign w_q_im = DATA_W'(r_dprod_im[63:RECIP10_SH]);

    always_ff @(posedge i_clk) begin
        r_dprod_re <= 64'(w_mag_re) * 64'(RECIP10);
        r_dprod_im <= 64'(w_mag_im) * 64'(RECIP10);
        r_dneg_re  <= i_shift_pair[31];
        r_dneg_im  <= i_shift_pair[63];
        r_sr       <= r_dneg_re ? $signed(-w_q_re) : $signed(w_q_re);
        r_si       <= r_dneg_im ? $signed(-w_q_im) : $signed(w_q_im);
    end

    // ---- sequencer ----
    t_bk_state r_state;
    t_bk_state n_state;

    logic [COORD_BITS-1:0]    r_x;
    logic [COORD_BITS-1:0]    r_y;
    logic signed [DATA_W-1:0] r_zr;
    logic signed [DATA_W-1:0] r_zi;
    logic signed [DATA_W-1:0] r_wr;
    logic signed [DATA_W-1:0] r_wi;
    logic signed [63:0]       r_prod;
    logic signed [63:0]       r_acc;
    logic [LIMIT_W-1:0]       r_n;

    logic                     r_strobe;
    logic [COORD_BITS-1:0]    r_out_x;
    logic [COORD_BITS-1:0]    r_out_y;
    logic [COUNT_BITS-1:0]    r_out_n;
    logic                     r_out_esc;

    logic signed [DATA_W-1:0] w_ma;
    logic signed [DATA_W-1:0] w_mb;
    logic [63:0]              w_mag2;
    logic                     w_escape;
    logic                     w_at_limit;
    logic [NW-1:0]            w_n_ext;

    assign w_mag2     = $unsigned(r_acc) + $unsigned(r_prod);
    assign w_escape   = (w_mag2 > BOUND);
    assign w_at_limit = (r_n >= i_limit);
    assign w_n_ext    = NW'(r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_ma    = r_zr;
        w_mb    = r_zr;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_CHECK;
                end
            end
            BK_CHECK: begin
                n_state = w_at_limit ? BK_IDLE : BK_SQ_ZR;
            end
            BK_SQ_ZR: begin
                n_state = BK_SQ_ZI;
            end
            BK_SQ_ZI: begin
                w_ma    = r_zi;
                w_mb    = r_zi;
                n_state = BK_TEST;
            end
            BK_TEST: begin
                w_ma    = r_wr;
                w_mb    = r_wr;
                n_state = w_escape ? BK_IDLE : BK_SQ_WI;
            end
            BK_SQ_WI: begin
                w_ma    = r_wi;
                w_mb    = r_wi;
                n_state = BK_MUL_X;
            end
            BK_MUL_X: begin
                w_ma    = r_wr;
                w_mb    = r_wi;
                n_state = BK_UPDATE;
            end
            BK_UPDATE: begin
                n_state = BK_CHECK;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // ---- datapath ----
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    {r_x, r_y, r_zr, r_zi} <= i_item;
                    r_n <= '0;
                end
            end
            BK_SQ_ZI: begin
                r_acc <= r_prod;
                r_wr  <= sat32(SAT_IN_W'(r_zr) + SAT_IN_W'(r_sr));
                r_wi  <= sat32(SAT_IN_W'(r_zi) + SAT_IN_W'(r_si));
            end
            BK_SQ_WI: begin
                r_acc <= r_prod;
            end
            BK_MUL_X: begin
                r_acc <= r_acc - r_prod;
            end
            BK_UPDATE: begin
                r_zr <= sat32(SAT_IN_W'(r_acc >>> FRAC_BITS) + SAT_IN_W'(i_const_re));
                r_zi <= sat32(SAT_IN_W'(r_prod >>> (FRAC_BITS - 1)) + SAT_IN_W'(i_const_im));
                r_n  <= r_n + LIMIT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // ---- result word, one cycle wide ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= ((r_state == BK_CHECK) && w_at_limit)
                     || ((r_state == BK_TEST) && w_escape);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == BK_CHECK) || (r_state == BK_TEST)) begin
            r_out_x   <= r_x;
            r_out_y   <= r_y;
            r_out_n   <= w_n_ext[COUNT_BITS-1:0];
            r_out_esc <= (r_state == BK_TEST);
        end
    end

    assign o_strobe     = r_strobe;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_iterations = r_out_n;
    assign o_escaped    = r_out_esc;

endmodule

// ----- sv/julia_escape_time_pixel_core.sv -----
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_core: Julia-set escape-time engine for one pixel
//
// Usage:
//   - Input: drive i_pixel_x/i_pixel_y and raise start; the word is taken on
//     a clock edge where start is high and busy is low.
//   - Config: unused indexes dropped; i_cfg_we/i_cfg_idx/i_cfg_data write one
//     register per cycle, only while the core is idle: a user rule, unchecked.
//   - Output: o_strobe is high for exactly one cycle with o_out_x, o_out_y,
//     o_iterations and o_escaped. The receiver cannot stall the core, so a
//     result word must be captured in the cycle it is shown.
//   - Path: start-point mapping in the front end, a queue hand-off, then the
//     escape loop on the shared multiplier of the back end.
//   - Pace: set by the back end's single multiplier loop; the front end maps
//     the next pixel meanwhile, up to the two-word queue depth.
//   - Reset (i_rst_n low, synchronous): config registers back to zero,
//     iteration_limit to 255, queue empty, no result pending.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_core #(
    parameter int COORD_BITS = jetp_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = jetp_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = jetp_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [COORD_BITS-1:0]           i_pixel_x,
    input  logic [COORD_BITS-1:0]           i_pixel_y,
    input  logic                            i_cfg_we,
    input  jetp_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [jetp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_strobe,
    output logic [COORD_BITS-1:0]           o_out_x,
    output logic [COORD_BITS-1:0]           o_out_y,
    output logic [COUNT_BITS-1:0]           o_iterations,
    output logic                            o_escaped
);
    import jetp_pkg::*;

    localparam int ITEM_W = 2 * COORD_BITS + 2 * DATA_W;

    // configuration registers
    logic signed [DATA_W-1:0] r_origin_re;
    logic signed [DATA_W-1:0] r_origin_im;
    logic signed [DATA_W-1:0] r_step_re;
    logic signed [DATA_W-1:0] r_step_im;
    logic signed [DATA_W-1:0] r_const_re;
    logic signed [DATA_W-1:0] r_const_im;
    logic [CFG_DATA_W-1:0]    r_shift_pair;
    logic [LIMIT_W-1:0]       r_limit;

    logic              w_take;
    logic              w_front_active;
    logic              w_push;
    logic [ITEM_W-1:0] w_push_item;
    logic              w_pop;
    logic [ITEM_W-1:0] w_head_item;
    logic              w_empty;
    logic              w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_re  <= '0;
            r_origin_im  <= '0;
            r_step_re    <= '0;
            r_step_im    <= '0;
            r_const_re   <= '0;
            r_const_im   <= '0;
            r_shift_pair <= '0;
            r_limit      <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ORIGIN_RE: r_origin_re  <= i_cfg_data[DATA_W-1:0];
                REG_ORIGIN_IM: r_origin_im  <= i_cfg_data[DATA_W-1:0];
                REG_STEP_RE:   r_step_re    <= i_cfg_data[DATA_W-1:0];
                REG_STEP_IM:   r_step_im    <= i_cfg_data[DATA_W-1:0];
                REG_CONST_RE:  r_const_re   <= i_cfg_data[DATA_W-1:0];
                REG_CONST_IM:  r_const_im   <= i_cfg_data[DATA_W-1:0];
                REG_SHIFT:     r_shift_pair <= i_cfg_data;
                REG_LIMIT:     r_limit      <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    // The front end holds one pixel at a time; a word is taken only when the
    // queue has room, so its push can never be refused.
    assign busy   = w_front_active | w_full;
    assign w_take = start & ~busy;

    jetp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_origin_re (r_origin_re),
        .i_origin_im (r_origin_im),
        .i_step_re   (r_step_re),
        .i_step_im   (r_step_im),
        .o_active    (w_front_active),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    jetp_fifo #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .i_pop   (w_pop),
        .o_data  (w_head_item),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    jetp_iter #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_iter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_item       (w_head_item),
        .o_pop        (w_pop),
        .i_const_re   (r_const_re),
        .i_const_im   (r_const_im),
        .i_shift_pair (r_shift_pair),
        .i_limit      (r_limit),
        .o_strobe     (o_strobe),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_iterations (o_iterations),
        .o_escaped    (o_escaped)
    );

    // ---- assertions ----
    a_take_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> busy)
        else $error("busy not raised after a pixel was taken");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue pop while empty");

endmodule

// ----- dv/tb_julia_escape_time_pixel_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_julia_escape_time_pixel_core: self-checking bench for the Julia pixel core
// A directed table sweeps the register extremes and the corner cases of the
// escape loop. Randomized views follow. Every result word is checked in order
// against its typed table value or an escape-time predictor in the bench.
// ----------------------------------------------------------------------------
module tb_julia_escape_time_pixel_core;
    import jetp_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int NW = COUNT_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;

    localparam int N_DIR            = 47;
    localparam int N_PHASES         = 8;
    localparam int PIXELS_PER_PHASE = 250;
    localparam int MAX_RAND_LIMIT   = 48;    // keeps the random part short
    localparam int DRAIN_CYCLES     = 32;    // catch stray strobes at the end

    // indexes outside the register map; the core must drop these writes
    localparam t_cfg_idx REG_SPARE_LO = 4'd8;
    localparam t_cfg_idx REG_SPARE_HI = 4'd15;

    // |z|^2 escape bound: 4.0 in Q(2*FB)
    localparam logic [63:0] ESC_BOUND = 64'd4 << (2 * FB);

    localparam logic signed [63:0] Q32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [NW-1:0] iters;
        logic          escaped;
    } t_pixel_word;

    typedef enum logic [1:0] {
        ROW_WRITE,          // register write, taken only with the core idle
        ROW_PIXEL,          // pixel, expectation from the predictor
        ROW_PIXEL_KNOWN     // pixel, expectation typed into the table
    } t_row_kind;

    typedef struct packed {
        t_row_kind     kind;
        t_cfg_idx      idx;
        logic [63:0]   data;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [NW-1:0] iters;
        logic          escaped;
    } t_dir_row;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    logic [CW-1:0]         i_pixel_x  = '0;
    logic [CW-1:0]         i_pixel_y  = '0;
    logic                  i_cfg_we   = 1'b0;
    t_cfg_idx              i_cfg_idx  = REG_ORIGIN_RE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_strobe;
    logic [CW-1:0]         o_out_x;
    logic [CW-1:0]         o_out_y;
    logic [NW-1:0]         o_iterations;
    logic                  o_escaped;

    julia_escape_time_pixel_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_iterations (o_iterations),
        .o_escaped    (o_escaped)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [63:0] view_regs [0:7];       // shadow of the register file
    t_pixel_word expected_words [$];    // one entry per accepted pixel, in order
    t_dir_row    directed_rows [N_DIR];
    int          mismatches = 0;
    int          max_gap    = 4;        // 0 gives back-to-back starts

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Generous cap: the slowest legal run takes about 2.4 ms.
    initial begin
        #15_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Escape-time predictor
    // ------------------------------------------------------------------------
    function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
        if (v > Q32_MAX) return Q32_MAX;
        if (v < Q32_MIN) return Q32_MIN;
        return v;
    endfunction

    // origin + floor((2*idx+1)*step / 2), clamped; the product is exact
    function automatic logic signed [63:0] map_axis(
        input logic [CW-1:0]      idx,
        input logic signed [31:0] origin,
        input logic signed [31:0] step
    );
        logic signed [63:0] k;
        logic signed [63:0] prod;
        k    = {idx, 1'b1};
        prod = k * step;
        return clamp_q(origin + (prod >>> 1));
    endfunction

    function automatic t_pixel_word escape_time_of(
        input logic [CW-1:0] px,
        input logic [CW-1:0] py
    );
        logic signed [31:0] half;
        logic signed [63:0] zr, zi, wr, wi, sr, si, cr, ci, re_part, im_part;
        logic [63:0]        sq_r, sq_i;
        logic [64:0]        mag2;
        int unsigned        n, lim;
        logic               esc;
        t_pixel_word        w;

        // shift / 10 truncates toward zero, as signed division does
        half = view_regs[REG_SHIFT][31:0];
        sr   = half;
        sr   = sr / 64'sd10;
        half = view_regs[REG_SHIFT][63:32];
        si   = half;
        si   = si / 64'sd10;
        half = view_regs[REG_CONST_RE][31:0];
        cr   = half;
        half = view_regs[REG_CONST_IM][31:0];
        ci   = half;
        zr   = map_axis(px, view_regs[REG_ORIGIN_RE][31:0], view_regs[REG_STEP_RE][31:0]);
        zi   = map_axis(py, view_regs[REG_ORIGIN_IM][31:0], view_regs[REG_STEP_IM][31:0]);
        lim  = view_regs[REG_LIMIT][NW-1:0];
        n    = 0;
        esc  = 1'b0;

        // test before update; a point exactly on the bound keeps going
        while (n < lim && !esc) begin
            sq_r = zr * zr;
            sq_i = zi * zi;
            mag2 = {1'b0, sq_r} + {1'b0, sq_i};
            if (mag2 > {1'b0, ESC_BOUND}) begin
                esc = 1'b1;
            end else begin
                wr      = clamp_q(zr + sr);
                wi      = clamp_q(zi + si);
                re_part = (wr * wr - wi * wi) >>> FB;
                im_part = (wr * wi) >>> (FB - 1);
                zr      = clamp_q(re_part + cr);
                zi      = clamp_q(im_part + ci);
                n++;
            end
        end

        w.x       = px;
        w.y       = py;
        w.iters   = n[NW-1:0];
        w.escaped = esc;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------------
    function automatic t_dir_row row_wr(input t_cfg_idx idx, input logic [63:0] data);
        return '{ROW_WRITE, idx, data, '0, '0, '0, 1'b0};
    endfunction

    function automatic t_dir_row row_px(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return '{ROW_PIXEL, REG_ORIGIN_RE, 64'd0, x, y, '0, 1'b0};
    endfunction

    function automatic t_dir_row row_known(
        input logic [CW-1:0] x,
        input logic [CW-1:0] y,
        input logic [NW-1:0] iters,
        input logic          esc
    );
        return '{ROW_PIXEL_KNOWN, REG_ORIGIN_RE, 64'd0, x, y, iters, esc};
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Config writes only land with the core idle: nothing owed and busy low.
    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        start <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0 || busy);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_SHIFT) begin
            view_regs[idx] = data;
        end else if (idx == REG_LIMIT) begin
            view_regs[idx] = {48'd0, data[15:0]};
        end else if (idx < REG_SHIFT) begin
            view_regs[idx] = {32'd0, data[31:0]};
        end
        // indexes past the map are dropped
    endtask

    // Start stays high across back-to-back words; it drops for a gap, a register write and the final drain.
    task automatic send_pixel(
        input logic [CW-1:0] x,
        input logic [CW-1:0] y,
        input logic          use_known,
        input logic [NW-1:0] iters,
        input logic          esc
    );
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        do @(posedge i_clk); while (busy);
        // word taken at this edge; config is frozen until the core drains
        if (use_known) begin
            expected_words.push_back('{x, y, iters, esc});
        end else begin
            expected_words.push_back(escape_time_of(x, y));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every strobe must match the oldest owed word
    // ------------------------------------------------------------------------
    function automatic void check_field(
        input string         name,
        input logic [NW-1:0] want,
        input logic [NW-1:0] got
    );
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_pixel_word want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, actual x=%0d y=%0d",
                         $time, o_out_x, o_out_y);
            end else begin
                want = expected_words.pop_front();
                check_field("out_x", NW'(want.x), NW'(o_out_x));
                check_field("out_y", NW'(want.y), NW'(o_out_y));
                check_field("iterations", want.iters, o_iterations);
                check_field("escaped", NW'(want.escaped), NW'(o_escaped));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [CW-1:0] x, y;
        logic [63:0]   data;
        int            q;
        bit            wild;

        for (int i = 0; i < 8; i++) view_regs[i] = 64'd0;
        view_regs[REG_LIMIT] = {48'd0, LIMIT_RESET};

        directed_rows = '{
            // reset view: all zero, limit 255, z pinned at 0 -> runs to limit
            row_known(12'd0, 12'd0, 16'd255, 1'b0),
            row_known(12'd4095, 12'd4095, 16'd255, 1'b0),
            // limit zero: no updates, never flagged
            row_wr(REG_LIMIT, 64'd0),
            row_known(12'd123, 12'd456, 16'd0, 1'b0),
            // start point far outside: escape before the first update
            row_wr(REG_LIMIT, 64'd10),
            row_wr(REG_ORIGIN_RE, 64'h0000_0000_7FFF_FFFF),
            row_known(12'd1, 12'd2, 16'd0, 1'b1),
            row_wr(REG_ORIGIN_RE, 64'hFFFF_FFFF_8000_0000),
            row_known(12'd4095, 12'd0, 16'd0, 1'b1),
            // outside point, limit zero still wins
            row_wr(REG_LIMIT, 64'd0),
            row_known(12'd7, 12'd7, 16'd0, 1'b0),
            // widest limit, junk in the upper data bits
            row_wr(REG_ORIGIN_RE, 64'd0),
            row_wr(REG_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF),
            row_known(12'd0, 12'd4095, 16'd65535, 1'b0),
            row_wr(REG_LIMIT, 64'd1),
            row_known(12'd2048, 12'd2048, 16'd1, 1'b0),
            // |z|^2 exactly 4: no escape on the first test
            row_wr(REG_LIMIT, 64'd20),
            row_wr(REG_ORIGIN_RE, 64'h0000_0000_2000_0000),
            row_px(12'd0, 12'd0),
            // update saturates high, then the most negative constant
            row_wr(REG_CONST_RE, 64'h0000_0000_7FFF_FFFF),
            row_px(12'd0, 12'd0),
            row_wr(REG_CONST_RE, 64'h0000_0000_8000_0000),
            row_px(12'd1, 12'd1),
            // one ulp past 2.0 escapes at once
            row_wr(REG_ORIGIN_RE, 64'h0000_0000_2000_0001),
            row_known(12'd5, 12'd9, 16'd0, 1'b1),
            // 64x64 view of [-1.5, 1.5]^2, c = -0.8 + 0.156i
            row_wr(REG_ORIGIN_RE, 64'hFFFF_FFFF_E800_0000),
            row_wr(REG_ORIGIN_IM, 64'hFFFF_FFFF_E800_0000),
            row_wr(REG_STEP_RE, 64'd12582912),
            row_wr(REG_STEP_IM, 64'd12582912),
            row_wr(REG_CONST_RE, 64'hFFFF_FFFF_F333_3333),
            row_wr(REG_CONST_IM, 64'd41875931),
            row_wr(REG_LIMIT, 64'd48),
            row_px(12'd32, 12'd32),
            row_px(12'd10, 12'd40),
            row_px(12'd63, 12'd0),
            // small negative shifts: division truncates, not floors
            row_wr(REG_SHIFT, 64'hFFFF_FFE7_FFFF_FFF1),
            row_px(12'd20, 12'd33),
            // shift extremes
            row_wr(REG_SHIFT, 64'h7FFF_FFFF_8000_0000),
            row_px(12'd31, 12'd31),
            // step extremes and a step of -1, start point clamps
            row_wr(REG_STEP_RE, 64'h0000_0000_FFFF_FFFF),
            row_wr(REG_STEP_IM, 64'h0000_0000_8000_0000),
            row_px(12'd4095, 12'd4095),
            row_wr(REG_STEP_RE, 64'h0000_0000_7FFF_FFFF),
            row_px(12'd4095, 12'd1),
            // writes past the map leave the view alone
            row_wr(REG_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF),
            row_wr(REG_SPARE_LO, 64'h0123_4567_89AB_CDEF),
            row_px(12'd32, 12'd32)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            case (directed_rows[i].kind)
                ROW_WRITE: begin
                    write_reg(directed_rows[i].idx, directed_rows[i].data);
                end
                ROW_PIXEL: begin
                    send_pixel(directed_rows[i].x, directed_rows[i].y, 1'b0, '0, 1'b0);
                end
                default: begin
                    send_pixel(directed_rows[i].x, directed_rows[i].y, 1'b1,
                               directed_rows[i].iters, directed_rows[i].escaped);
                end
            endcase
        end

        // Random views: most are plausible windows where pixels straddle the
        // set boundary; every fourth is raw random words (mostly early escapes,
        // but it hits the clamps and the shift extremes).
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wild = (ph % 4) == 3;
            for (t_cfg_idx r = REG_ORIGIN_RE; r <= REG_LIMIT; r++) begin
                if (r == REG_LIMIT) begin
                    data = {$urandom, 16'($urandom), 16'($urandom_range(1, MAX_RAND_LIMIT))};
                end else if (wild) begin
                    data = {$urandom, $urandom};
                end else begin
                    case (r)
                        REG_ORIGIN_RE, REG_ORIGIN_IM: begin
                            q = int'($urandom_range(0, 5 << 27)) - (1 << 29);
                        end
                        REG_STEP_RE, REG_STEP_IM: begin
                            q = int'($urandom_range(1 << 18, 1 << 23));
                            if ($urandom_range(0, 3) == 0) q = -q;
                        end
                        REG_CONST_RE, REG_CONST_IM: begin
                            q = int'($urandom_range(0, 1 << 29)) - (1 << 28);
                        end
                        default: begin
                            q = 0;
                        end
                    endcase
                    data = {$urandom, q};
                    if (r == REG_SHIFT) begin
                        data = {32'(int'($urandom_range(0, 1 << 30)) - (1 << 29)),
                                32'(int'($urandom_range(0, 1 << 30)) - (1 << 29))};
                    end
                end
                write_reg(r, data);
            end
            write_reg(t_cfg_idx'(REG_SPARE_LO +
                                 $urandom_range(0, REG_SPARE_HI - REG_SPARE_LO)),
                      {$urandom, $urandom});

            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                // stretches of back-to-back words between gappy stretches
                if (n % 50 == 0) max_gap = ($urandom_range(0, 2) == 0) ? 0 : 4;
                if (wild || $urandom_range(0, 9) == 0) begin
                    x = CW'($urandom);
                    y = CW'($urandom);
                end else begin
                    x = CW'($urandom_range(0, 63));
                    y = CW'($urandom_range(0, 63));
                end
                send_pixel(x, y, 1'b0, '0, 1'b0);
            end
        end

        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/jetp_pkg.sv
sv/jetp_fifo.sv
sv/jetp_front.sv
sv/jetp_iter.sv
sv/julia_escape_time_pixel_core.sv
dv/tb_julia_escape_time_pixel_core.sv
